// File: hw/rtl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared constants and types for the counter-priority task picker.
// ----------------------------------------------------------------------------
package cpt_pkg;

  // Table geometry
  localparam int NUM_SLOTS = 8;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Field widths
  localparam int SLOT_W    = 3;
  localparam int CTR_W     = 9;
  localparam int PRI_W     = 8;
  localparam int RCH_SHIFT = 2;

  // Command codes carried in tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SCHED = 1'b1;

  // One task slot
  typedef struct packed {
    logic             present;
    logic             runnable;
    logic [CTR_W-1:0] counter;
    logic [PRI_W-1:0] priority_val;
  } entry_t;

  // Table write port
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } wr_t;

  // Shared unit results
  typedef struct packed {
    logic             better;
    logic [CTR_W-1:0] rch_counter;
  } alu_out_t;

endpackage

// File: hw/rtl/cpt_table.sv
// ----------------------------------------------------------------------------
// cpt_table
// Task slot storage: one write port, one read port addressed by the sequencer.
// ----------------------------------------------------------------------------
module cpt_table (
  input  logic                    clk,
  input  logic                    rst,
  input  cpt_pkg::wr_t            wr,
  input  logic [cpt_pkg::IDX_W-1:0] rd_idx,
  output cpt_pkg::entry_t         rd_entry
);

  cpt_pkg::entry_t slots [cpt_pkg::NUM_SLOTS];

  // Storage, cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cpt_pkg::NUM_SLOTS; i++) begin
        slots[i] <= '0;
      end
    end else if (wr.en) begin
      slots[wr.idx] <= wr.entry;
    end
  end

  // Read at the sequencer index
  assign rd_entry = slots[rd_idx];

endmodule

// File: hw/rtl/cpt_alu.sv
// ----------------------------------------------------------------------------
// cpt_alu
// Shared unit: candidate compare for the pick and the recharge of one slot.
// ----------------------------------------------------------------------------
module cpt_alu (
  input  cpt_pkg::entry_t            entry,
  input  logic [cpt_pkg::CTR_W-1:0]  best,
  output cpt_pkg::alu_out_t          res
);

  logic [cpt_pkg::CTR_W:0] sum;

  // counter >> 2 plus priority, saturated; absent slots keep their counter
  assign sum = (cpt_pkg::CTR_W+1)'(entry.counter >> cpt_pkg::RCH_SHIFT)
             + (cpt_pkg::CTR_W+1)'(entry.priority_val);

  always_comb begin
    // Candidate beats the best so far (strict, so the first seen wins ties)
    res.better = entry.present && entry.runnable && (entry.counter > best);
    if (!entry.present) begin
      res.rch_counter = entry.counter;
    end else if (sum[cpt_pkg::CTR_W]) begin
      res.rch_counter = '1;
    end else begin
      res.rch_counter = sum[cpt_pkg::CTR_W-1:0];
    end
  end

endmodule

// File: hw/rtl/counter_priority_task_picker_top.sv
// ----------------------------------------------------------------------------
// counter_priority_task_picker_top
// Task slot table with a counter/priority scheduler and recharge pass.
//
// Input channel (s_*): tuser is the command, 0 writes one slot, 1 asks for a
// scheduling decision. A write takes effect in the cycle it is accepted and
// gives no output word. A schedule request gives exactly one output word on
// the m_* channel with the chosen slot, a found flag and a recharged flag.
// One compare unit visits one slot per cycle, highest slot first. If the pick
// finds no candidate, a recharge pass (one slot per cycle, lowest slot first)
// and a second pick follow before the word is put out.
// s_tready is high only while no decision is in progress, so one request is
// handled at a time; writes are taken back to back.
// The output word sits in a register until taken; a stalled receiver holds
// the finished decision and blocks the next one from completing.
// Reset clears every slot (not present, not runnable, zero counter and
// priority) and drops any pending word.
// ----------------------------------------------------------------------------
module counter_priority_task_picker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] slot, [3] present, [4] runnable, [13:5] time_left,
  // [21:14] priority_req, [23:22] zero
  input  logic [23:0] s_tdata,
  // [0] command
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] chosen_slot, [3] found, [4] recharged, [7:5] zero
  output logic [7:0]  m_tdata
);

  localparam int IDX_W = cpt_pkg::IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(cpt_pkg::NUM_SLOTS - 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PICK = 2'd1;
  localparam logic [1:0] ST_RCH  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                state;
  logic [IDX_W-1:0]          idx;
  logic [cpt_pkg::CTR_W-1:0] best;
  logic [IDX_W-1:0]          at;
  logic                      any;
  logic                      rech;

  cpt_pkg::wr_t      wr;
  cpt_pkg::entry_t   rd_entry;
  cpt_pkg::alu_out_t alu_res;

  logic [cpt_pkg::SLOT_W-1:0] in_slot;
  logic                       in_accept;
  logic                       any_now;
  logic [cpt_pkg::SLOT_W-1:0] out_slot;

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign in_slot   = s_tdata[2:0];
  assign any_now   = any || alu_res.better;
  assign out_slot  = any ? cpt_pkg::SLOT_W'(at) : '0;

  cpt_table u_table (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_idx   (idx),
    .rd_entry (rd_entry)
  );

  cpt_alu u_alu (
    .entry (rd_entry),
    .best  (best),
    .res   (alu_res)
  );

  // Table write: input word in idle, recharged counter during the pass
  always_comb begin
    wr = '0;
    if (state == ST_RCH) begin
      wr.en            = 1'b1;
      wr.idx           = idx;
      wr.entry         = rd_entry;
      wr.entry.counter = alu_res.rch_counter;
    end else if (in_accept && (s_tuser[0] == cpt_pkg::CMD_WRITE)) begin
      wr.en                 = (32'(in_slot) < cpt_pkg::NUM_SLOTS);
      wr.idx                = IDX_W'(in_slot);
      wr.entry.present      = s_tdata[3];
      wr.entry.runnable     = s_tdata[4];
      wr.entry.counter      = s_tdata[13:5];
      wr.entry.priority_val = s_tdata[21:14];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      best  <= '0;
      at    <= '0;
      any   <= 1'b0;
      rech  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept && (s_tuser[0] == cpt_pkg::CMD_SCHED)) begin
            state <= ST_PICK;
            idx   <= LAST_IDX;
            best  <= '0;
            at    <= '0;
            any   <= 1'b0;
            rech  <= 1'b0;
          end
        end
        ST_PICK: begin
          if (alu_res.better) begin
            best <= rd_entry.counter;
            at   <= idx;
            any  <= 1'b1;
          end
          if (idx == '0) begin
            if (any_now || rech) begin
              state <= ST_DONE;
            end else begin
              state <= ST_RCH;
              rech  <= 1'b1;
            end
          end else begin
            idx <= idx - 1'b1;
          end
        end
        ST_RCH: begin
          if (idx == LAST_IDX) begin
            state <= ST_PICK;
            best  <= '0;
            at    <= '0;
            any   <= 1'b0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tdata <= {3'b000, rech, any, out_slot};
    end
  end

endmodule
